@@ hw/rtl/assert_macros.svh @@
// assertion macros shared by the rtl files
// no dependencies; the bodies are empty when SYNTH is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// same-cycle implication, checked outside reset
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication, checked outside reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

@@ hw/rtl/spra_pkg.sv @@
// types and constants of the strict priority round-robin node arbiter
// no dependencies
`timescale 1ns / 1ps

package spra_pkg;

    localparam int NUM_NODES_DEF = 32;
    localparam int NUM_LEVELS    = 8;
    localparam int LEVEL_W       = 3;
    localparam int NODE_W        = 5;
    localparam int ACTION_W      = 3;

    // action codes
    localparam logic [ACTION_W-1:0] ACT_SET_MAX_RDY = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_SET_MAX_PRI = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_SET_MIN_RDY = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_SET_MIN_PRI = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_SEL_MAX     = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_SEL_MIN     = 3'd5;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [NODE_W-1:0]   node;
        logic                ready_req;
        logic [LEVEL_W-1:0]  priority_req;
    } spra_req_t;

    typedef struct packed {
        logic              found;
        logic [NODE_W-1:0] winner;
    } spra_rsp_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } spra_state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic rd_en;
        logic finish;
    } spra_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic sel_in;
        logic scan_last;
    } spra_status_t;

endpackage

@@ hw/rtl/spra_ctrl.sv @@
// controller state machine of the node arbiter
// depends on spra_pkg
`timescale 1ns / 1ps

module spra_ctrl
    import spra_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  spra_status_t status,
    output spra_cmd_t    cmd,
    output logic         busy
);

    spra_state_t state_reg;
    spra_state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start && status.sel_in)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (status.scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            ST_SCAN:
            begin
                cmd.rd_en = 1'b1;
            end
            ST_DRAIN:
            begin
                cmd = '0;
            end
            ST_FINISH:
            begin
                cmd.finish = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

@@ hw/rtl/spra_dp.sv @@
// datapath of the node arbiter: node tables, pointers, scan accumulators
// depends on spra_pkg
`timescale 1ns / 1ps

module spra_dp
    import spra_pkg::*;
#(
    parameter int NUM_NODES = NUM_NODES_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  spra_req_t    req,
    input  spra_cmd_t    cmd,
    output spra_status_t status,
    output logic         done,
    output spra_rsp_t    rsp
);

    localparam int NW = $clog2(NUM_NODES);
    localparam logic [NW-1:0] LAST_IDX = NW'(NUM_NODES - 1);

    // node tables: ready bits and priority valid bits in flops, priorities in memory
    logic [LEVEL_W-1:0] prio_mem [2][NUM_NODES];
    logic               ready_reg [2][NUM_NODES];
    logic               pval_reg  [2][NUM_NODES];
    logic [NW-1:0]      ptr_reg   [2][NUM_LEVELS];

    // scan control
    logic               arb_reg;
    logic [NW-1:0]      cnt_reg;
    logic               rd_vld_reg;
    logic [NW-1:0]      rd_idx_reg;
    logic               rd_rdy_reg;
    logic               rd_pv_reg;
    logic [LEVEL_W-1:0] prio_rd_reg;

    // per level accumulators
    logic               any_hit_reg  [NUM_LEVELS];
    logic               any_hit_next [NUM_LEVELS];
    logic [NW-1:0]      any_idx_reg  [NUM_LEVELS];
    logic [NW-1:0]      any_idx_next [NUM_LEVELS];
    logic               ge_hit_reg   [NUM_LEVELS];
    logic               ge_hit_next  [NUM_LEVELS];
    logic [NW-1:0]      ge_idx_reg   [NUM_LEVELS];
    logic [NW-1:0]      ge_idx_next  [NUM_LEVELS];

    logic               done_reg;
    spra_rsp_t          rsp_reg;

    // request decode
    logic               node_ok;
    logic [NW-1:0]      wr_node;
    logic               wr_arb;
    logic               wr_rdy;
    logic               wr_pri;
    logic               is_sel;

    assign node_ok  = int'(req.node) < NUM_NODES;
    assign wr_node  = NW'(req.node);
    assign wr_arb   = (req.action == ACT_SET_MIN_RDY) || (req.action == ACT_SET_MIN_PRI);
    assign wr_rdy   = cmd.load && node_ok &&
                      ((req.action == ACT_SET_MAX_RDY) || (req.action == ACT_SET_MIN_RDY));
    assign wr_pri   = cmd.load && node_ok &&
                      ((req.action == ACT_SET_MAX_PRI) || (req.action == ACT_SET_MIN_PRI));
    assign is_sel   = (req.action == ACT_SEL_MAX) || (req.action == ACT_SEL_MIN);

    assign status.sel_in    = is_sel;
    assign status.scan_last = (cnt_reg == LAST_IDX);

    // priority memory: written by set actions, read once per scan cycle
    always_ff @(posedge clk)
    begin
        if (wr_pri)
        begin
            prio_mem[wr_arb][wr_node] <= req.priority_req;
        end
        if (cmd.rd_en)
        begin
            prio_rd_reg <= prio_mem[arb_reg][cnt_reg];
        end
    end

    // ready and priority valid flops
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < 2; a++)
            begin
                for (int n = 0; n < NUM_NODES; n++)
                begin
                    ready_reg[a][n] <= 1'b0;
                    pval_reg[a][n]  <= 1'b0;
                end
            end
        end
        else
        begin
            if (wr_rdy)
            begin
                ready_reg[wr_arb][wr_node] <= req.ready_req;
            end
            if (wr_pri)
            begin
                pval_reg[wr_arb][wr_node] <= 1'b1;
            end
        end
    end

    // scan counter and read pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            arb_reg    <= 1'b0;
            cnt_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= cmd.rd_en;
            if (cmd.load && is_sel)
            begin
                arb_reg <= (req.action == ACT_SEL_MIN);
                cnt_reg <= '0;
            end
            else if (cmd.rd_en)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            rd_idx_reg <= cnt_reg;
            rd_rdy_reg <= ready_reg[arb_reg][cnt_reg];
            rd_pv_reg  <= pval_reg[arb_reg][cnt_reg];
        end
    end

    // accumulate first ready node and first at or after the level pointer
    logic [LEVEL_W-1:0] eff_pri;
    logic               node_hit;
    logic               at_or_after;

    assign eff_pri     = rd_pv_reg ? prio_rd_reg : '0;
    assign node_hit    = rd_vld_reg && rd_rdy_reg;
    assign at_or_after = rd_idx_reg >= ptr_reg[arb_reg][eff_pri];

    always_comb
    begin
        for (int l = 0; l < NUM_LEVELS; l++)
        begin
            any_hit_next[l] = any_hit_reg[l];
            any_idx_next[l] = any_idx_reg[l];
            ge_hit_next[l]  = ge_hit_reg[l];
            ge_idx_next[l]  = ge_idx_reg[l];
        end
        if (cmd.load)
        begin
            for (int l = 0; l < NUM_LEVELS; l++)
            begin
                any_hit_next[l] = 1'b0;
                ge_hit_next[l]  = 1'b0;
            end
        end
        else if (node_hit)
        begin
            if (!any_hit_reg[eff_pri])
            begin
                any_hit_next[eff_pri] = 1'b1;
                any_idx_next[eff_pri] = rd_idx_reg;
            end
            if (at_or_after && !ge_hit_reg[eff_pri])
            begin
                ge_hit_next[eff_pri] = 1'b1;
                ge_idx_next[eff_pri] = rd_idx_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int l = 0; l < NUM_LEVELS; l++)
            begin
                any_hit_reg[l] <= 1'b0;
                ge_hit_reg[l]  <= 1'b0;
            end
        end
        else
        begin
            for (int l = 0; l < NUM_LEVELS; l++)
            begin
                any_hit_reg[l] <= any_hit_next[l];
                ge_hit_reg[l]  <= ge_hit_next[l];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int l = 0; l < NUM_LEVELS; l++)
        begin
            any_idx_reg[l] <= any_idx_next[l];
            ge_idx_reg[l]  <= ge_idx_next[l];
        end
    end

    // pick the highest level with a ready node
    logic               found;
    logic [LEVEL_W-1:0] win_lvl;
    logic [NW-1:0]      win_idx;
    logic [NW-1:0]      ptr_new;

    always_comb
    begin
        found   = 1'b0;
        win_lvl = '0;
        for (int l = 0; l < NUM_LEVELS; l++)
        begin
            if (any_hit_reg[l])
            begin
                found   = 1'b1;
                win_lvl = LEVEL_W'(l);
            end
        end
    end

    assign win_idx = ge_hit_reg[win_lvl] ? ge_idx_reg[win_lvl] : any_idx_reg[win_lvl];
    assign ptr_new = (win_idx == LAST_IDX) ? '0 : win_idx + 1'b1;

    // round-robin pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < 2; a++)
            begin
                for (int l = 0; l < NUM_LEVELS; l++)
                begin
                    ptr_reg[a][l] <= '0;
                end
            end
        end
        else if (cmd.finish && found)
        begin
            ptr_reg[arb_reg][win_lvl] <= ptr_new;
        end
    end

    // result register: set actions answer at once, selects at finish
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (cmd.load && !is_sel) || cmd.finish;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            rsp_reg.found  <= found;
            rsp_reg.winner <= found ? NODE_W'(win_idx) : '0;
        end
        else if (cmd.load)
        begin
            rsp_reg <= '0;
        end
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

@@ hw/rtl/strict_priority_rr_node_arbiter.sv @@
// top level of the strict priority round-robin node arbiter pair
// depends on spra_pkg, spra_ctrl, spra_dp and assert_macros.svh
`timescale 1ns / 1ps

// Two arbiters (max-rate and min-rate) share one command port. An item is taken when start
// is high and busy is low. A set action writes its item if the node is below NUM_NODES, and
// its result (found = 0, winner = 0) strobes on done in the next cycle, while busy stays
// low, so set items can follow every cycle. A select scans the node table one node per
// cycle through the single read port of the priority memory; the drain state then takes
// the last read and the finish state picks the winner. busy stays high through the scan,
// drain and finish states, and the result is registered from the finish state onto done.
// Results show for exactly one cycle and cannot be held off, so the receiver must take them
// as they come. No clearing pass is run after reset.

`include "assert_macros.svh"

module strict_priority_rr_node_arbiter
    import spra_pkg::*;
#(
    parameter int NUM_NODES = NUM_NODES_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  spra_req_t req,
    output logic      done,
    output spra_rsp_t rsp
);

    spra_cmd_t    cmd;
    spra_status_t status;

    // controller
    spra_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    // datapath
    spra_dp #(
        .NUM_NODES (NUM_NODES)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .cmd    (cmd),
        .status (status),
        .done   (done),
        .rsp    (rsp)
    );

    // checks
    logic accept_set;
    logic accept_sel;

    assign accept_sel = start && !busy &&
                        ((req.action == ACT_SEL_MAX) || (req.action == ACT_SEL_MIN));
    assign accept_set = start && !busy && !accept_sel;

    `ASSERT_NEXT(a_set_answers, clk, rst_n, accept_set, done && !rsp.found, "set item without result")
    `ASSERT_NEXT(a_sel_holds, clk, rst_n, accept_sel, busy && !done, "select did not hold busy")
    `ASSERT_IMPL(a_miss_zero, clk, rst_n, done && !rsp.found, rsp.winner == '0, "miss with winner")
    `ASSERT_IMPL(a_win_range, clk, rst_n, done && rsp.found, int'(rsp.winner) < NUM_NODES, "winner out of range")

endmodule
